// ----- hdl/liu_pkg.sv -----
// shared types and constants of the linear interpolation unit
// no dependencies; used by liu_front, liu_out, the top level, its checker and the testbench
package liu_pkg;

   localparam int FIELD_WIDTH = 32;

   typedef logic [FIELD_WIDTH-1:0] field_type;

endpackage

// ----- hdl/liu_front.sv -----
// first stage: operand trimming, differences, slope sign and zero span flag
// depends on liu_pkg
module liu_front #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  liu_pkg::field_type    x_start,
   input  liu_pkg::field_type    x_query,
   input  liu_pkg::field_type    x_end,
   input  liu_pkg::field_type    y_start,
   input  liu_pkg::field_type    y_end,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [DATA_WIDTH-1:0] dxq,
   output logic [DATA_WIDTH-1:0] dy,
   output logic [DATA_WIDTH-1:0] span,
   output logic [DATA_WIDTH-1:0] ys,
   output logic                  rising,
   output logic                  zero
);

   localparam int EXT_WIDTH =
      (DATA_WIDTH > liu_pkg::FIELD_WIDTH) ? DATA_WIDTH : liu_pkg::FIELD_WIDTH;

   logic [EXT_WIDTH-1:0]  xs_e, xq_e, xe_e, ys_e, ye_e;
   logic [DATA_WIDTH-1:0] xs_w, xq_w, xe_w, ys_w, ye_w;
   logic                  valid_ff, valid_in;
   logic [DATA_WIDTH-1:0] dxq_ff, dxq_in, dy_ff, dy_in, span_ff, span_in, ys_ff;
   logic                  rising_ff, rising_in, zero_ff, zero_in;

   assign xs_e = EXT_WIDTH'(x_start);
   assign xq_e = EXT_WIDTH'(x_query);
   assign xe_e = EXT_WIDTH'(x_end);
   assign ys_e = EXT_WIDTH'(y_start);
   assign ye_e = EXT_WIDTH'(y_end);
   assign xs_w = xs_e[DATA_WIDTH-1:0];
   assign xq_w = xq_e[DATA_WIDTH-1:0];
   assign xe_w = xe_e[DATA_WIDTH-1:0];
   assign ys_w = ys_e[DATA_WIDTH-1:0];
   assign ye_w = ye_e[DATA_WIDTH-1:0];

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      dxq_in    = xq_w - xs_w;
      span_in   = xe_w - xs_w;
      rising_in = ye_w > ys_w;
      dy_in     = rising_in ? (ye_w - ys_w) : (ys_w - ye_w);
      zero_in   = (xe_w == xs_w);
      valid_in  = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         dxq_ff    <= dxq_in;
         dy_ff     <= dy_in;
         span_ff   <= span_in;
         ys_ff     <= ys_w;
         rising_ff <= rising_in;
         zero_ff   <= zero_in;
      end
   end

   assign out_valid = valid_ff;
   assign dxq       = dxq_ff;
   assign dy        = dy_ff;
   assign span      = span_ff;
   assign ys        = ys_ff;
   assign rising    = rising_ff;
   assign zero      = zero_ff;

endmodule

// ----- hdl/liu_mul.sv -----
// two-stage truncated multiplier: half-width partial products, then their sum
// no package dependencies; carries the side fields of an item along
module liu_mul #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [DATA_WIDTH-1:0] mul_a,
   input  logic [DATA_WIDTH-1:0] mul_b,
   input  logic [DATA_WIDTH-1:0] span_i,
   input  logic [DATA_WIDTH-1:0] ys_i,
   input  logic                  rising_i,
   input  logic                  zero_i,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [DATA_WIDTH-1:0] prod,
   output logic [DATA_WIDTH-1:0] span_o,
   output logic [DATA_WIDTH-1:0] ys_o,
   output logic                  rising_o,
   output logic                  zero_o
);

   localparam int LO_W = DATA_WIDTH / 2;
   localparam int HI_W = DATA_WIDTH - LO_W;

   logic [LO_W-1:0]       a_lo, b_lo;
   logic [HI_W-1:0]       a_hi, b_hi;

   // partial product stage
   logic                  pv_ff, pv_in, p_ready;
   logic [2*LO_W-1:0]     pll_ff, pll_in;
   logic [HI_W-1:0]       plh_ff, plh_in, phl_ff, phl_in;
   logic [DATA_WIDTH-1:0] pspan_ff, pys_ff;
   logic                  prising_ff, pzero_ff;

   // sum stage
   logic                  sv_ff, sv_in;
   logic [DATA_WIDTH-1:0] pll_ext, cross_ext, prod_ff, prod_in;
   logic [HI_W-1:0]       cross_sum;
   logic [DATA_WIDTH-1:0] sspan_ff, sys_ff;
   logic                  srising_ff, szero_ff;

   assign a_lo = mul_a[LO_W-1:0];
   assign a_hi = mul_a[DATA_WIDTH-1:LO_W];
   assign b_lo = mul_b[LO_W-1:0];
   assign b_hi = mul_b[DATA_WIDTH-1:LO_W];

   assign p_ready  = !sv_ff || out_ready;
   assign in_ready = !pv_ff || p_ready;

   always_comb begin
      pll_in = (2*LO_W)'(a_lo) * (2*LO_W)'(b_lo);
      plh_in = HI_W'(a_lo) * b_hi;
      phl_in = a_hi * HI_W'(b_lo);
      pv_in  = in_ready ? in_valid : pv_ff;
   end

   always_comb begin
      pll_ext   = DATA_WIDTH'(pll_ff);
      cross_sum = plh_ff + phl_ff;
      cross_ext = {cross_sum, {LO_W{1'b0}}};
      prod_in   = pll_ext + cross_ext;
      sv_in     = p_ready ? pv_ff : sv_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
         sv_ff <= 1'b0;
      end else begin
         pv_ff <= pv_in;
         sv_ff <= sv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         pll_ff     <= pll_in;
         plh_ff     <= plh_in;
         phl_ff     <= phl_in;
         pspan_ff   <= span_i;
         pys_ff     <= ys_i;
         prising_ff <= rising_i;
         pzero_ff   <= zero_i;
      end
   end

   always_ff @(posedge clock) begin
      if (p_ready && pv_ff) begin
         prod_ff    <= prod_in;
         sspan_ff   <= pspan_ff;
         sys_ff     <= pys_ff;
         srising_ff <= prising_ff;
         szero_ff   <= pzero_ff;
      end
   end

   assign out_valid = sv_ff;
   assign prod      = prod_ff;
   assign span_o    = sspan_ff;
   assign ys_o      = sys_ff;
   assign rising_o  = srising_ff;
   assign zero_o    = szero_ff;

endmodule

// ----- hdl/liu_div_stage.sv -----
// one step of the restoring divider: one quotient bit per register stage
// no package dependencies; chained by the top level
module liu_div_stage #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [DATA_WIDTH-1:0] rem_i,
   input  logic [DATA_WIDTH-1:0] work_i,
   input  logic [DATA_WIDTH-1:0] span_i,
   input  logic [DATA_WIDTH-1:0] ys_i,
   input  logic                  rising_i,
   input  logic                  zero_i,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [DATA_WIDTH-1:0] rem_o,
   output logic [DATA_WIDTH-1:0] work_o,
   output logic [DATA_WIDTH-1:0] span_o,
   output logic [DATA_WIDTH-1:0] ys_o,
   output logic                  rising_o,
   output logic                  zero_o
);

   logic                  valid_ff, valid_in;
   logic [DATA_WIDTH:0]   trial, diff;
   logic                  fits;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in, work_ff, work_in, span_ff, ys_ff;
   logic                  rising_ff, zero_ff;

   assign in_ready = !valid_ff || out_ready;

   // shift in the next dividend bit, subtract the divisor when it fits
   always_comb begin
      trial    = {rem_i, work_i[DATA_WIDTH-1]};
      diff     = trial - {1'b0, span_i};
      fits     = trial >= {1'b0, span_i};
      rem_in   = fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
      work_in  = {work_i[DATA_WIDTH-2:0], fits};
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rem_ff    <= rem_in;
         work_ff   <= work_in;
         span_ff   <= span_i;
         ys_ff     <= ys_i;
         rising_ff <= rising_i;
         zero_ff   <= zero_i;
      end
   end

   assign out_valid = valid_ff;
   assign rem_o     = rem_ff;
   assign work_o    = work_ff;
   assign span_o    = span_ff;
   assign ys_o      = ys_ff;
   assign rising_o  = rising_ff;
   assign zero_o    = zero_ff;

endmodule

// ----- hdl/liu_out.sv -----
// output register: zero span override, signed step from y_start
// depends on liu_pkg
module liu_out #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [DATA_WIDTH-1:0] quot_i,
   input  logic [DATA_WIDTH-1:0] ys_i,
   input  logic                  rising_i,
   input  logic                  zero_i,
   output logic                  out_valid,
   input  logic                  out_ready,
   output liu_pkg::field_type    y_value
);

   localparam int EXT_WIDTH =
      (DATA_WIDTH > liu_pkg::FIELD_WIDTH) ? DATA_WIDTH : liu_pkg::FIELD_WIDTH;

   logic                  valid_ff, valid_in;
   logic [DATA_WIDTH-1:0] quot, y_w;
   logic [EXT_WIDTH-1:0]  y_ext;
   liu_pkg::field_type    y_ff, y_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      quot     = zero_i ? '0 : quot_i;
      y_w      = rising_i ? (ys_i + quot) : (ys_i - quot);
      y_ext    = EXT_WIDTH'(y_w);
      y_in     = y_ext[liu_pkg::FIELD_WIDTH-1:0];
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         y_ff <= y_in;
      end
   end

   assign out_valid = valid_ff;
   assign y_value   = y_ff;

endmodule

// ----- hdl/linear_interpolation_unit_core.sv -----
// top level of the linear interpolation unit: front stage, multiplier, divider chain, output
// depends on liu_pkg, liu_front, liu_mul, liu_div_stage and liu_out
//
// Each item carries two end points and a query x and yields one interpolated y,
// y_start +/- floor((x_query - x_start) * |y_end - y_start| / (x_end - x_start)),
// all arithmetic modulo 2^DATA_WIDTH, with a zero span giving y_start. The block
// is a fully pipelined chain with no state between items: one item can enter every
// clock cycle unless a stall on rsp_ready has backed up the whole chain. The divider
// resolves one quotient bit per register stage; the front stage and two multiplier
// stages come before it and the output register after it. Every stage holds its
// item under backpressure and empty stages keep filling, so up to DATA_WIDTH + 4
// items can be in flight while rsp_ready is low.
module linear_interpolation_unit_core #(
   parameter int DATA_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  liu_pkg::field_type req_x_start,
   input  liu_pkg::field_type req_x_query,
   input  liu_pkg::field_type req_x_end,
   input  liu_pkg::field_type req_y_start,
   input  liu_pkg::field_type req_y_end,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output liu_pkg::field_type rsp_y_value
);

   logic                  f_valid, f_ready;
   logic [DATA_WIDTH-1:0] f_dxq, f_dy, f_span, f_ys;
   logic                  f_rising, f_zero;

   logic                  m_valid, m_ready;
   logic [DATA_WIDTH-1:0] m_prod, m_span, m_ys;
   logic                  m_rising, m_zero;

   logic                  d_valid  [0:DATA_WIDTH];
   logic                  d_ready  [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] d_rem    [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] d_work   [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] d_span   [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] d_ys     [0:DATA_WIDTH];
   logic                  d_rising [0:DATA_WIDTH];
   logic                  d_zero   [0:DATA_WIDTH];

   liu_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .x_start   (req_x_start),
      .x_query   (req_x_query),
      .x_end     (req_x_end),
      .y_start   (req_y_start),
      .y_end     (req_y_end),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .dxq       (f_dxq),
      .dy        (f_dy),
      .span      (f_span),
      .ys        (f_ys),
      .rising    (f_rising),
      .zero      (f_zero)
   );

   liu_mul #(.DATA_WIDTH(DATA_WIDTH)) u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .mul_a     (f_dxq),
      .mul_b     (f_dy),
      .span_i    (f_span),
      .ys_i      (f_ys),
      .rising_i  (f_rising),
      .zero_i    (f_zero),
      .out_valid (m_valid),
      .out_ready (m_ready),
      .prod      (m_prod),
      .span_o    (m_span),
      .ys_o      (m_ys),
      .rising_o  (m_rising),
      .zero_o    (m_zero)
   );

   // divider chain head: remainder starts at zero, dividend fills the work word
   assign d_valid[0]  = m_valid;
   assign m_ready     = d_ready[0];
   assign d_rem[0]    = '0;
   assign d_work[0]   = m_prod;
   assign d_span[0]   = m_span;
   assign d_ys[0]     = m_ys;
   assign d_rising[0] = m_rising;
   assign d_zero[0]   = m_zero;

   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_div
      liu_div_stage #(.DATA_WIDTH(DATA_WIDTH)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (d_valid[i]),
         .in_ready  (d_ready[i]),
         .rem_i     (d_rem[i]),
         .work_i    (d_work[i]),
         .span_i    (d_span[i]),
         .ys_i      (d_ys[i]),
         .rising_i  (d_rising[i]),
         .zero_i    (d_zero[i]),
         .out_valid (d_valid[i+1]),
         .out_ready (d_ready[i+1]),
         .rem_o     (d_rem[i+1]),
         .work_o    (d_work[i+1]),
         .span_o    (d_span[i+1]),
         .ys_o      (d_ys[i+1]),
         .rising_o  (d_rising[i+1]),
         .zero_o    (d_zero[i+1])
      );
   end

   liu_out #(.DATA_WIDTH(DATA_WIDTH)) u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid[DATA_WIDTH]),
      .in_ready  (d_ready[DATA_WIDTH]),
      .quot_i    (d_work[DATA_WIDTH]),
      .ys_i      (d_ys[DATA_WIDTH]),
      .rising_i  (d_rising[DATA_WIDTH]),
      .zero_i    (d_zero[DATA_WIDTH]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .y_value   (rsp_y_value)
   );

endmodule

// ----- hdl/liu_checker.sv -----
// port-level checker for linear_interpolation_unit_core, with its bind
// depends on liu_pkg and the top level's port list
module liu_checker #(
   parameter int DATA_WIDTH = 32
) (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input liu_pkg::field_type req_x_start,
   input liu_pkg::field_type req_x_query,
   input liu_pkg::field_type req_x_end,
   input liu_pkg::field_type req_y_start,
   input liu_pkg::field_type req_y_end,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input liu_pkg::field_type rsp_y_value
);

   localparam int DEPTH = DATA_WIDTH + 4;
   localparam int CNT_W = $clog2(DEPTH + 2);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             req_take, rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // items taken and not yet delivered
   always_comb begin
      count_in = count_ff + CNT_W'(req_take) - CNT_W'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_y_value))
      else $error("result item dropped or changed while stalled");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> count_ff != '0)
      else $error("result item with no item in flight");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("more items in flight than pipeline stages");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_W'(DEPTH) && !rsp_ready |-> !req_ready)
      else $error("item accepted into a full pipeline");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind linear_interpolation_unit_core liu_checker #(.DATA_WIDTH(DATA_WIDTH)) u_liu_checker (.*);

// ----- tb/linear_interpolation_unit_core_test.sv -----
// testbench for linear_interpolation_unit_core: directed and random segment queries
// with random idling on both channels, checked against an in-bench interpolation predictor
// depends on liu_pkg and linear_interpolation_unit_core
module linear_interpolation_unit_core_test;

   typedef struct {
      liu_pkg::field_type x_start;
      liu_pkg::field_type x_query;
      liu_pkg::field_type x_end;
      liu_pkg::field_type y_start;
      liu_pkg::field_type y_end;
      bit                 wait_drain;
   } interp_query_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   liu_pkg::field_type req_x_start = '0;
   liu_pkg::field_type req_x_query = '0;
   liu_pkg::field_type req_x_end = '0;
   liu_pkg::field_type req_y_start = '0;
   liu_pkg::field_type req_y_end = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   liu_pkg::field_type rsp_y_value;

   interp_query_type   query_queue[$];
   interp_query_type   driven_query;
   liu_pkg::field_type expected_y_by_seq[int];
   int                 accepted_count = 0;
   int                 checked_count = 0;
   int                 mismatch_count = 0;
   int                 total_queries = 0;
   int                 cycle_count = 0;
   bit                 driver_busy;
   bit                 load_next;
   logic               no_idle_window;

   linear_interpolation_unit_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_x_start (req_x_start),
      .req_x_query (req_x_query),
      .req_x_end   (req_x_end),
      .req_y_start (req_y_start),
      .req_y_end   (req_y_end),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_y_value (rsp_y_value)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   assign no_idle_window = (cycle_count >= 300) && (cycle_count < 700);

   function automatic liu_pkg::field_type interpolate_y(input interp_query_type q);
      liu_pkg::field_type dx_query;
      liu_pkg::field_type dx_span;
      liu_pkg::field_type dy_abs;
      liu_pkg::field_type product;
      liu_pkg::field_type quotient;
      logic               rising;
      dx_query = q.x_query - q.x_start;
      dx_span  = q.x_end - q.x_start;
      rising   = q.y_end > q.y_start;
      dy_abs   = rising ? q.y_end - q.y_start : q.y_start - q.y_end;
      product  = dx_query * dy_abs;
      quotient = (dx_span != '0) ? product / dx_span : '0;
      return rising ? q.y_start + quotient : q.y_start - quotient;
   endfunction

   task automatic add_query(input liu_pkg::field_type xs, input liu_pkg::field_type xq,
                            input liu_pkg::field_type xe, input liu_pkg::field_type ys,
                            input liu_pkg::field_type ye, input bit drain);
      interp_query_type q;
      q.x_start    = xs;
      q.x_query    = xq;
      q.x_end      = xe;
      q.y_start    = ys;
      q.y_end      = ye;
      q.wait_drain = drain;
      query_queue.push_back(q);
      total_queries++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         driver_busy = req_valid;
         if (req_valid && req_ready) begin
            expected_y_by_seq[accepted_count] = interpolate_y(driven_query);
            accepted_count <= accepted_count + 1;
            driver_busy = 1'b0;
         end
         if (!driver_busy) begin
            load_next = 1'b0;
            if (query_queue.size() > 0 && (no_idle_window || $urandom_range(99) >= 23)) begin
               // hold a wait_drain item back until the pipeline has emptied
               if (!query_queue[0].wait_drain ||
                   (accepted_count == checked_count && !(req_valid && req_ready)))
                  load_next = 1'b1;
            end
            if (load_next) begin
               driven_query = query_queue.pop_front();
               req_x_start <= driven_query.x_start;
               req_x_query <= driven_query.x_query;
               req_x_end   <= driven_query.x_end;
               req_y_start <= driven_query.y_start;
               req_y_end   <= driven_query.y_end;
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (checked_count >= accepted_count) begin
               mismatch_count++;
               $display("%0t: unexpected item, expected none, actual y_value %h",
                        $time, rsp_y_value);
            end else begin
               if (rsp_y_value !== expected_y_by_seq[checked_count]) begin
                  mismatch_count++;
                  $display("%0t: y_value mismatch, expected %h, actual %h",
                           $time, expected_y_by_seq[checked_count], rsp_y_value);
               end
               expected_y_by_seq.delete(checked_count);
            end
            checked_count <= checked_count + 1;
         end
         rsp_ready <= no_idle_window || ($urandom_range(99) >= 23);
      end
   end

   initial begin
      liu_pkg::field_type xs;
      liu_pkg::field_type xe;
      liu_pkg::field_type xq;
      liu_pkg::field_type ys;
      liu_pkg::field_type ye;
      liu_pkg::field_type span;
      liu_pkg::field_type dy;
      int                 kind;

      // directed items
      add_query('0, '0, '0, '0, '0, 1'b0);
      add_query('1, '1, '1, '1, '1, 1'b0);
      add_query(32'd100, 32'd150, 32'd100, 32'd777, 32'd999, 1'b0);
      add_query('1, 32'h1234_5678, '1, $urandom, $urandom, 1'b0);
      add_query(32'd0, 32'd5, 32'd10, 32'd42, 32'd42, 1'b0);
      add_query(32'd0, 32'd5, 32'd10, 32'd0, 32'd100, 1'b0);
      add_query(32'd0, 32'd5, 32'd10, 32'd100, 32'd0, 1'b0);
      add_query(32'd0, 32'd1, 32'd3, 32'd0, 32'd2, 1'b0);
      add_query(32'd0, 32'd2, 32'd3, 32'd0, 32'd2, 1'b0);
      add_query(32'd10, 32'd5, 32'd20, 32'd0, 32'd10, 1'b0);
      add_query(32'd0, 32'd30, 32'd10, 32'd0, 32'd10, 1'b0);
      add_query(32'd0, '1, '1, 32'd0, '1, 1'b0);
      add_query('1, 32'h8000_0000, 32'd0, 32'd0, 32'd3, 1'b0);
      add_query(32'd0, 32'h1234_5678, 32'd1, 32'd7, 32'd9, 1'b0);
      add_query(32'd16, 32'd32, 32'd32, 32'hFFFF_FFF0, '1, 1'b0);
      add_query(32'd0, 32'd100, 32'd1, 32'd5, 32'd0, 1'b0);
      add_query(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAB, 32'h5555_5555, 32'hAAAA_AAAA,
                1'b0);
      add_query(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5554, 32'hAAAA_AAAA, 32'h5555_5555,
                1'b0);
      add_query(32'd0, 32'h7FFF_FFFF, '1, 32'd0, '1, 1'b0);
      add_query('1, '0, 32'h7FFF_FFFF, '1, '0, 1'b0);

      // random items
      for (int n = 0; n < 800; n++) begin
         kind = $urandom_range(99);
         xs   = $urandom;
         ys   = $urandom;
         span = $urandom_range(65535, 1);
         dy   = $urandom_range(65535);
         if (kind < 55) begin
            xe = xs + span;
            xq = xs + $urandom_range(span, 0);
         end else if (kind < 65) begin
            xe = xs;
            xq = $urandom;
            dy = $urandom;
         end else if (kind < 75) begin
            xe = xs + span;
            xq = xs + $urandom_range(span, 0);
            dy = '0;
         end else if (kind < 85) begin
            xe = xs + span;
            xq = $urandom_range(1) ? xs - $urandom_range(255, 1)
                                    : xe + $urandom_range(255, 1);
         end else begin
            xe = $urandom;
            xq = $urandom;
            dy = $urandom;
         end
         ye = $urandom_range(1) ? ys + dy : ys - dy;
         add_query(xs, xq, xe, ys, ye, (n == 0) || ($urandom_range(49) == 0));
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock); while (checked_count < total_queries);
      repeat (50) @(posedge clock);

      if (mismatch_count == 0 && checked_count == accepted_count)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/liu_pkg.sv
hdl/liu_front.sv
hdl/liu_mul.sv
hdl/liu_div_stage.sv
hdl/liu_out.sv
hdl/linear_interpolation_unit_core.sv
hdl/liu_checker.sv
tb/linear_interpolation_unit_core_test.sv
